// ===== rtl/fdsc_pkg.sv =====
// Shared types and constants for the frame difference scene cut detector.
`timescale 1ns / 1ps
package fdsc_pkg;

   localparam int MAX_PIXELS = 131072;
   localparam int PIX_W      = 8;
   localparam int THR_W      = 16;
   localparam int NORM_SHIFT = 8;
   localparam int IDX_W      = $clog2(MAX_PIXELS + 1);
   localparam int ADDR_W     = $clog2(MAX_PIXELS);
   localparam int SUM_W      = $clog2(MAX_PIXELS * 255 + 1);
   localparam int PROD_W     = THR_W + IDX_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [IDX_W-1:0]     MAX_COUNT     = IDX_W'(MAX_PIXELS);
   localparam logic [THR_W-1:0]     THR_RESET     = THR_W'(6554);
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = REG_IDX_W'(0);

   typedef struct packed {
      logic [PIX_W-1:0] gray_pixel;
      logic             last_in_frame;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_difference;
      logic             frame_done;
      logic             compared;
      logic             scene_change;
      logic             frame_overflow;
   } rsp_word_type;

   // difference stage to decision stage
   typedef struct packed {
      logic [PIX_W-1:0]  diff;
      logic              last;
      logic              cmp_ok;
      logic              ovf;
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] product;
   } stage_type;

endpackage

// ===== rtl/fdsc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read (read-first).
`timescale 1ns / 1ps
module fdsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fdsc_front.sv =====
// Pixel indexing, frame store access, absolute difference and frame accumulator.
`timescale 1ns / 1ps
module fdsc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  fdsc_pkg::req_word_type       req_data,
   input  logic [fdsc_pkg::THR_W-1:0]   threshold,
   input  logic                         take,
   output logic                         stage_valid,
   output fdsc_pkg::stage_type          stage_data
);

   logic                          fire;
   logic                          in_range;
   logic [fdsc_pkg::IDX_W-1:0]    count_next;
   logic [fdsc_pkg::PIX_W-1:0]    old_pix;
   logic [fdsc_pkg::PIX_W-1:0]    abs_diff;
   logic [fdsc_pkg::PIX_W-1:0]    diff;
   logic [fdsc_pkg::SUM_W-1:0]    sum_total;
   logic                          s1_move;

   logic [fdsc_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                          ovf_ff, ovf_in;
   logic                          havep_ff, havep_in;
   logic [fdsc_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic                          s1_v_ff, s1_v_in;
   logic [fdsc_pkg::PIX_W-1:0]    s1_pix_ff;
   logic                          s1_last_ff;
   logic                          s1_inrange_ff;
   logic                          s1_havep_ff;
   logic                          s1_ovf_ff;
   logic [fdsc_pkg::IDX_W-1:0]    s1_count_ff;

   assign req_ready  = !s1_v_ff || take;
   assign fire       = req_valid && req_ready;
   assign s1_move    = s1_v_ff && take;
   assign in_range   = (idx_ff != fdsc_pkg::MAX_COUNT);
   assign count_next = in_range ? idx_ff + 1'b1 : idx_ff;

   fdsc_ram #(
      .WIDTH(fdsc_pkg::PIX_W),
      .DEPTH(fdsc_pkg::MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (fire && in_range),
      .wr_addr (idx_ff[fdsc_pkg::ADDR_W-1:0]),
      .wr_data (req_data.gray_pixel),
      .rd_en   (fire && in_range),
      .rd_addr (idx_ff[fdsc_pkg::ADDR_W-1:0]),
      .rd_data (old_pix)
   );

   always_comb begin
      abs_diff  = (old_pix > s1_pix_ff) ? old_pix - s1_pix_ff : s1_pix_ff - old_pix;
      diff      = (s1_havep_ff && s1_inrange_ff) ? abs_diff : '0;
      sum_total = sum_ff + fdsc_pkg::SUM_W'(diff);

      stage_valid        = s1_v_ff;
      stage_data.diff    = diff;
      stage_data.last    = s1_last_ff;
      stage_data.cmp_ok  = s1_havep_ff && !s1_ovf_ff;
      stage_data.ovf     = s1_ovf_ff;
      stage_data.sum     = sum_total;
      stage_data.product = fdsc_pkg::PROD_W'(threshold) * fdsc_pkg::PROD_W'(s1_count_ff);
   end

   always_comb begin
      idx_in   = idx_ff;
      ovf_in   = ovf_ff;
      havep_in = havep_ff;
      sum_in   = sum_ff;
      s1_v_in  = s1_v_ff;
      if (fire) begin
         idx_in   = req_data.last_in_frame ? '0 : count_next;
         ovf_in   = req_data.last_in_frame ? 1'b0 : (ovf_ff || !in_range);
         havep_in = havep_ff || req_data.last_in_frame;
      end
      if (s1_move) begin
         sum_in = s1_last_ff ? '0 : sum_total;
      end
      if (fire) begin
         s1_v_in = 1'b1;
      end else if (take) begin
         s1_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         ovf_ff   <= 1'b0;
         havep_ff <= 1'b0;
         sum_ff   <= '0;
         s1_v_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         ovf_ff   <= ovf_in;
         havep_ff <= havep_in;
         sum_ff   <= sum_in;
         s1_v_ff  <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_pix_ff     <= req_data.gray_pixel;
         s1_last_ff    <= req_data.last_in_frame;
         s1_inrange_ff <= in_range;
         s1_havep_ff   <= havep_ff;
         s1_ovf_ff     <= ovf_ff || !in_range;
         s1_count_ff   <= count_next;
      end
   end

   idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= fdsc_pkg::MAX_COUNT)
      else $error("pixel index beyond store capacity");

   idx_wrap: assert property (@(posedge clock) disable iff (reset)
      fire && req_data.last_in_frame |=> idx_ff == '0 && !ovf_ff && havep_ff)
      else $error("frame end did not restart the frame state");

endmodule

// ===== rtl/fdsc_decide.sv =====
// Threshold decision stage and output register.
`timescale 1ns / 1ps
module fdsc_decide (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stage_valid,
   input  fdsc_pkg::stage_type      stage_data,
   output logic                     take,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fdsc_pkg::rsp_word_type   rsp_data
);

   logic                        out_move;
   logic                        compared;
   logic [fdsc_pkg::PROD_W-1:0] lhs;
   fdsc_pkg::rsp_word_type      word;

   logic                        s2_v_ff, s2_v_in;
   fdsc_pkg::stage_type         s2_ff;
   logic                        out_v_ff, out_v_in;
   fdsc_pkg::rsp_word_type      out_ff;

   assign out_move = !out_v_ff || rsp_ready;
   assign take     = !s2_v_ff || out_move;

   always_comb begin
      lhs                   = fdsc_pkg::PROD_W'({s2_ff.sum, {fdsc_pkg::NORM_SHIFT{1'b0}}});
      compared              = s2_ff.last && s2_ff.cmp_ok;
      word.pixel_difference = s2_ff.diff;
      word.frame_done       = s2_ff.last;
      word.compared         = compared;
      word.scene_change     = compared && (lhs > s2_ff.product);
      word.frame_overflow   = s2_ff.last && s2_ff.ovf;

      s2_v_in  = take ? stage_valid : s2_v_ff;
      out_v_in = out_move ? s2_v_ff : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && stage_valid) begin
         s2_ff <= stage_data;
      end
      if (out_move && s2_v_ff) begin
         out_ff <= word;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   cut_needs_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.scene_change |-> rsp_data.compared)
      else $error("scene change without a comparison");

   compare_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.compared |-> rsp_data.frame_done && !rsp_data.frame_overflow)
      else $error("comparison outside a clean frame end");

   overflow_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_overflow |-> rsp_data.frame_done)
      else $error("overflow flag away from frame end");

endmodule

// ===== rtl/frame_difference_scene_cut.sv =====
// Top level of the frame difference scene cut detector with its register port.
`timescale 1ns / 1ps
// Usage:
//   req_*  : one gray pixel word per handshake in raster order, last_in_frame
//            set on the final pixel of each frame.
//   rsp_*  : one word per pixel: absolute difference to the same position of
//            the previous frame; on the frame's last pixel also frame_done,
//            compared, scene_change (sum*256 > threshold_q16*count) and
//            frame_overflow (frame longer than the 131072-entry frame store).
//   psel/penable/pwrite/paddr/pwdata : register 0 at byte address 0 holds
//            threshold_q16; write it only while the block is idle.
//   Path: a taken pixel passes the s1, s2 and output registers to rsp_data.
//   Throughput: one pixel per cycle while rsp_ready keeps up, set by the single
//            frame store read and write issued in the accept cycle.
//   Reset: clears the pixel index, sums and the previous-frame flag, so the
//            first frame is stored but not compared; the store is not cleared.
//   Stall: when rsp_ready is low the internal stages keep filling, and
//            req_ready drops only once every stage holds a word.
module frame_difference_scene_cut (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fdsc_pkg::req_word_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fdsc_pkg::rsp_word_type            rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fdsc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fdsc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fdsc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   logic [fdsc_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           csr_write;
   logic                           take;
   logic                           stage_valid;
   fdsc_pkg::stage_type            stage_data;

   logic [fdsc_pkg::THR_W-1:0]     thr_ff, thr_in;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[fdsc_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      thr_in = thr_ff;
      if (csr_write && reg_idx == fdsc_pkg::REG_THRESHOLD) begin
         thr_in = pwdata[fdsc_pkg::THR_W-1:0];
      end
      prdata = '0;
      if (reg_idx == fdsc_pkg::REG_THRESHOLD) begin
         prdata = fdsc_pkg::CSR_DATA_W'(thr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= fdsc_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   fdsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .threshold   (thr_ff),
      .take        (take),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   fdsc_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== verif/frame_difference_scene_cut_tb.sv =====
// Self-checking testbench for the frame difference scene cut detector.
`timescale 1ns / 1ps
module frame_difference_scene_cut_tb;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int SETTLE_CYCLES = 6;
   localparam int FIRST_LEN     = 400;
   localparam int PHASE_ITEMS   = 140;
   localparam logic [fdsc_pkg::CSR_ADDR_W-1:0] THR_ADDR   = {fdsc_pkg::REG_THRESHOLD, 2'b00};
   localparam logic [fdsc_pkg::CSR_ADDR_W-1:0] SPARE_ADDR = fdsc_pkg::CSR_ADDR_W'(4);

   typedef enum logic [1:0] {STIM_PIXEL, STIM_TYPED, STIM_CSR} stim_kind_type;
   typedef enum logic [1:0] {FILL_RANDOM, FILL_NEAR, FILL_EXTREME, FILL_FLAT} fill_mode_type;

   typedef struct packed {
      stim_kind_type                       kind;
      logic [fdsc_pkg::CSR_ADDR_W-1:0]     addr;
      logic [fdsc_pkg::CSR_DATA_W-1:0]     value;
      fdsc_pkg::req_word_type              word;
      fdsc_pkg::rsp_word_type              known;
   } stim_row_type;

   // known = {pixel_difference, frame_done, compared, scene_change, frame_overflow}
   localparam stim_row_type DIRECTED [20] = '{
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd255, 1'b0}, {8'd255, 4'b0000}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd0,   1'b0}, {8'd0,   4'b0000}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd128, 1'b0}, {8'd128, 4'b0000}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd1,   1'b1}, {8'd1,   4'b1110}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd255, 1'b1}, {8'd0,   4'b1100}},
      '{STIM_CSR,   THR_ADDR,   32'd0,     {8'd0,   1'b0}, {8'd0,   4'b0000}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd255, 1'b1}, {8'd0,   4'b1100}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd254, 1'b1}, {8'd1,   4'b1110}},
      '{STIM_CSR,   THR_ADDR,   32'd65535, {8'd0,   1'b0}, {8'd0,   4'b0000}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd0,   1'b0}, {8'd254, 4'b0000}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd255, 1'b1}, {8'd255, 4'b1100}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd255, 1'b1}, {8'd255, 4'b1100}},
      '{STIM_CSR,   THR_ADDR,   32'd65279, {8'd0,   1'b0}, {8'd0,   4'b0000}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd0,   1'b1}, {8'd255, 4'b1110}},
      '{STIM_CSR,   SPARE_ADDR, 32'd65535, {8'd0,   1'b0}, {8'd0,   4'b0000}},
      '{STIM_TYPED, THR_ADDR,   32'd0,     {8'd255, 1'b1}, {8'd255, 4'b1110}},
      '{STIM_CSR,   THR_ADDR,   32'd6554,  {8'd0,   1'b0}, {8'd0,   4'b0000}},
      '{STIM_PIXEL, THR_ADDR,   32'd0,     {8'h55,  1'b0}, {8'd0,   4'b0000}},
      '{STIM_PIXEL, THR_ADDR,   32'd0,     {8'hAA,  1'b0}, {8'd0,   4'b0000}},
      '{STIM_PIXEL, THR_ADDR,   32'd0,     {8'h0F,  1'b1}, {8'd0,   4'b0000}}
   };

   logic                            clock;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   fdsc_pkg::req_word_type          req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   fdsc_pkg::rsp_word_type          rsp_data;
   logic                            psel      = 1'b0;
   logic                            penable   = 1'b0;
   logic                            pwrite    = 1'b0;
   logic [fdsc_pkg::CSR_ADDR_W-1:0] paddr     = '0;
   logic [fdsc_pkg::CSR_DATA_W-1:0] pwdata    = '0;
   logic [fdsc_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   // shadow of the detector state
   logic [fdsc_pkg::PIX_W-1:0]  prev_store [0:fdsc_pkg::MAX_PIXELS-1];
   int unsigned                 pix_count  = 0;
   longint unsigned             diff_total = 0;
   bit                          have_prev  = 1'b0;
   bit                          ovf_seen   = 1'b0;
   logic [fdsc_pkg::THR_W-1:0]  thr_q16    = fdsc_pkg::THR_RESET;

   fdsc_pkg::rsp_word_type      diff_words_due [$];
   int                          idle_pct   = 0;
   int                          fail_count = 0;

   frame_difference_scene_cut dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic fdsc_pkg::rsp_word_type difference_step(fdsc_pkg::req_word_type w);
      fdsc_pkg::rsp_word_type     r;
      logic [fdsc_pkg::PIX_W-1:0] stored;
      r = '0;
      if (pix_count < fdsc_pkg::MAX_PIXELS) begin
         stored = prev_store[pix_count];
         if (have_prev)
            r.pixel_difference = (stored > w.gray_pixel) ? stored - w.gray_pixel
                                                         : w.gray_pixel - stored;
         prev_store[pix_count] = w.gray_pixel;
         diff_total += r.pixel_difference;
         pix_count++;
      end else begin
         ovf_seen = 1'b1;
      end
      if (w.last_in_frame) begin
         r.frame_done     = 1'b1;
         r.frame_overflow = ovf_seen;
         if (have_prev && !ovf_seen) begin
            r.compared     = 1'b1;
            r.scene_change = (diff_total * 64'd256) > (64'(thr_q16) * 64'(pix_count));
         end
         have_prev  = 1'b1;
         pix_count  = 0;
         diff_total = 0;
         ovf_seen   = 1'b0;
      end
      return r;
   endfunction

   function automatic int draw_gap();
      if ($urandom_range(0, 99) < idle_pct)
         return $urandom_range(1, 16);
      return 0;
   endfunction

   function automatic logic [fdsc_pkg::PIX_W-1:0] pick_pixel(fill_mode_type mode,
                                                            logic [fdsc_pkg::PIX_W-1:0] flat);
      int v;
      case (mode)
         FILL_NEAR: begin
            if (pix_count >= fdsc_pkg::MAX_PIXELS)
               return fdsc_pkg::PIX_W'($urandom_range(0, 255));
            v = int'(prev_store[pix_count]) + int'($urandom_range(0, 6)) - 3;
            if (v < 0)
               v = 0;
            if (v > 255)
               v = 255;
            return fdsc_pkg::PIX_W'(v);
         end
         FILL_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
         FILL_FLAT:    return flat;
         default:      return fdsc_pkg::PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [fdsc_pkg::PIX_W-1:0] pixel, input logic last,
                             input bit typed, input fdsc_pkg::rsp_word_type known);
      int                     gap;
      fdsc_pkg::req_word_type w;
      fdsc_pkg::rsp_word_type got;
      w.gray_pixel    = pixel;
      w.last_in_frame = last;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      got = difference_step(w);
      diff_words_due.push_back(typed ? known : got);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (diff_words_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [fdsc_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [fdsc_pkg::CSR_DATA_W-1:0] data,
                             output logic [fdsc_pkg::CSR_DATA_W-1:0] rd);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (wr && addr == THR_ADDR)
         thr_q16 = data[fdsc_pkg::THR_W-1:0];
   endtask

   task automatic set_register(input logic [fdsc_pkg::CSR_ADDR_W-1:0] addr,
                               input logic [fdsc_pkg::CSR_DATA_W-1:0] data);
      logic [fdsc_pkg::CSR_DATA_W-1:0] rd;
      wait_idle();
      csr_access(1'b1, addr, data, rd);
      csr_access(1'b0, THR_ADDR, '0, rd);
      if (rd[fdsc_pkg::THR_W-1:0] !== thr_q16) begin
         $error("threshold_q16 readback: expected %0d, got %0d", thr_q16,
                rd[fdsc_pkg::THR_W-1:0]);
         fail_count++;
      end
   endtask

   // result side: random back-pressure and comparison
   initial begin : rsp_side
      int                     hold;
      fdsc_pkg::rsp_word_type want;
      wait (reset === 1'b0);
      forever begin
         hold = draw_gap();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (diff_words_due.size() == 0) begin
            $error("result word with nothing pending: %h", rsp_data);
            fail_count++;
         end else begin
            want = diff_words_due.pop_front();
            if (rsp_data.pixel_difference !== want.pixel_difference) begin
               $error("pixel_difference: expected %0d, got %0d",
                      want.pixel_difference, rsp_data.pixel_difference);
               fail_count++;
            end
            if (rsp_data.frame_done !== want.frame_done) begin
               $error("frame_done: expected %0d, got %0d", want.frame_done,
                      rsp_data.frame_done);
               fail_count++;
            end
            if (rsp_data.compared !== want.compared) begin
               $error("compared: expected %0d, got %0d", want.compared, rsp_data.compared);
               fail_count++;
            end
            if (rsp_data.scene_change !== want.scene_change) begin
               $error("scene_change: expected %0d, got %0d", want.scene_change,
                      rsp_data.scene_change);
               fail_count++;
            end
            if (rsp_data.frame_overflow !== want.frame_overflow) begin
               $error("frame_overflow: expected %0d, got %0d", want.frame_overflow,
                      rsp_data.frame_overflow);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("frame_difference_scene_cut_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      int            frame_items;
      int            len;
      int            pick;
      fill_mode_type mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // first frame covers every position later frames reach; its head is zero
      idle_pct = 1;
      for (int p = 0; p < FIRST_LEN; p++)
         send_pixel(p < 32 ? 8'd0 : fdsc_pkg::PIX_W'($urandom_range(0, 255)),
                    p == FIRST_LEN - 1, 1'b0, '0);

      idle_pct = 30;
      foreach (DIRECTED[i]) begin
         case (DIRECTED[i].kind)
            STIM_CSR:   set_register(DIRECTED[i].addr, DIRECTED[i].value);
            STIM_TYPED: send_pixel(DIRECTED[i].word.gray_pixel,
                                   DIRECTED[i].word.last_in_frame, 1'b1,
                                   DIRECTED[i].known);
            default:    send_pixel(DIRECTED[i].word.gray_pixel,
                                   DIRECTED[i].word.last_in_frame, 1'b0, '0);
         endcase
      end

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_register(THR_ADDR, 32'd0);
            1: set_register(THR_ADDR, 32'd65535);
            default: begin
               pick = $urandom_range(0, 2);
               if (pick == 0)
                  set_register(THR_ADDR, $urandom_range(0, 65535));
               else if (pick == 1)
                  set_register(THR_ADDR, $urandom_range(0, 2000));
               else
                  set_register(THR_ADDR, $urandom_range(20000, 40000));
            end
         endcase
         if (ph == 3)
            set_register(SPARE_ADDR, $urandom);
         case ($urandom_range(0, 4))
            0: idle_pct = 0;
            1: idle_pct = 5;
            2: idle_pct = 25;
            3: idle_pct = 60;
            default: idle_pct = 95;
         endcase
         frame_items = 0;
         while (frame_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               len = $urandom_range(100, FIRST_LEN);
            else if (pick < 3)
               len = 1;
            else
               len = $urandom_range(2, 32);
            mode = fill_mode_type'($urandom_range(0, 3));
            for (int p = 0; p < len; p++) begin
               if ($urandom_range(0, 299) == 0)
                  wait_idle();
               send_pixel(pick_pixel(mode, fdsc_pkg::PIX_W'($urandom_range(0, 255))),
                          p == len - 1, 1'b0, '0);
            end
            frame_items += len;
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (diff_words_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("frame_difference_scene_cut_tb OK");
      else
         $display("frame_difference_scene_cut_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/fdsc_pkg.sv
rtl/fdsc_ram.sv
rtl/fdsc_front.sv
rtl/fdsc_decide.sv
rtl/frame_difference_scene_cut.sv
verif/frame_difference_scene_cut_tb.sv
